>>> rtl/hge_pkg.sv
// shared types, constants and aes helpers for the half-gates evaluator
package hge_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_XOR   = 2'd2;
  localparam logic [1:0] CMD_AND   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] dest_wire;
    logic [11:0] src_a;
    logic [11:0] src_b;
    logic [63:0] word0_hi;
    logic [63:0] word0_lo;
    logic [63:0] word1_hi;
    logic [63:0] word1_lo;
  } hge_req_t;

  typedef struct packed {
    logic [63:0] label_hi;
    logic [63:0] label_lo;
  } hge_res_t;

  // queued request with its tweak values fixed by the front part
  typedef struct packed {
    hge_req_t    req;
    logic [63:0] tweak_a;
    logic [63:0] tweak_b;
  } hge_job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_WAIT, ST_HASH, ST_DONE
  } hge_state_t;

  localparam logic [127:0] FIXED_KEY = 128'h249c32ea5ce63109aeaacda062ec1df3;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the aes state sits at bits [8i+7:8i]
  function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = SBOX[st[8*(r+4*((c+r)&3)) +: 8]];
      end
    end
    m = t;
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c) +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      x = a0 ^ a1 ^ a2 ^ a3;
      m[8*(4*c) +: 8]   = a0 ^ x ^ xtime(a0 ^ a1);
      m[8*(4*c+1) +: 8] = a1 ^ x ^ xtime(a1 ^ a2);
      m[8*(4*c+2) +: 8] = a2 ^ x ^ xtime(a2 ^ a3);
      m[8*(4*c+3) +: 8] = a3 ^ x ^ xtime(a3 ^ a0);
    end
    return (last ? t : m) ^ rk;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rcon);
    logic [127:0] n;
    logic [31:0] w;
    w = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rcon};
    n[31:0]   = k[31:0] ^ w;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    return n;
  endfunction

endpackage

>>> rtl/hge_front.sv
// front part: takes requests, attaches tweaks, tracks the gate counter
module hge_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hge_pkg::hge_req_t req,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic              q_full,
  output logic              busy,
  output logic              q_push,
  output hge_pkg::hge_job_t q_job
);
  import hge_pkg::*;

  logic [31:0] gate_counter;
  logic [31:0] base;

  assign busy   = q_full;
  assign q_push = start && !q_full;

  // tweaks use the counter before this gate
  always_comb begin
    q_job.req     = req;
    q_job.tweak_a = {32'd0, gate_counter};
    q_job.tweak_b = {32'd0, base} + {32'd0, gate_counter};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_counter <= '0;
      base         <= '0;
    end else begin
      if (cfg_we) base <= cfg_data;
      if (q_push) begin
        if (req.cmd == CMD_START) gate_counter <= '0;
        else if (req.cmd == CMD_AND) gate_counter <= gate_counter + 32'd1;
      end
    end
  end
endmodule

>>> rtl/hge_queue.sv
// two-entry request queue between front and back
module hge_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hge_pkg::hge_job_t din,
  output logic              full,
  output logic              nonempty,
  input  logic              pop,
  output hge_pkg::hge_job_t dout
);
  import hge_pkg::*;

  hge_job_t    slot [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign dout     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/hge_back.sv
// back part: wire store, two round-iterative aes cores, result strobe
module hge_back #(
  parameter int WIRE_COUNT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_nonempty,
  input  hge_pkg::hge_job_t q_job,
  output logic              q_pop,
  output logic              done,
  output hge_pkg::hge_res_t result
);
  import hge_pkg::*;

  // wire indexes are 12 bits wide, so at most 4096 entries are reachable
  localparam int AW = (WIRE_COUNT > 4096) ? 12 : (WIRE_COUNT > 1) ? $clog2(WIRE_COUNT) : 1;

  logic [127:0] store [WIRE_COUNT];

  hge_state_t   state, state_next;
  hge_job_t     job;
  logic [127:0] rd_a, rd_b;
  logic         ok_a, ok_b;
  logic [127:0] st_a, st_b, sa, sb, rkey;
  logic [7:0]   rcon;
  logic [3:0]   round;
  logic [127:0] res_word;
  logic         wr_en;

  // label as {hi, lo}; shifted and tweaked hash input
  function automatic logic [127:0] hash_in(input logic [127:0] x, input logic [63:0] tw);
    return {x[126:64], 1'b0, {x[62:0], 1'b0} ^ tw};
  endfunction

  logic [127:0] la, lb;
  assign la = ok_a ? rd_a : '0;
  assign lb = ok_b ? rd_b : '0;

  // next state
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    unique case (state)
      ST_IDLE: if (q_nonempty) begin
        state_next = ST_READ;
        q_pop = 1'b1;
      end
      ST_READ: state_next = ST_WAIT;
      ST_WAIT: state_next = (job.req.cmd == CMD_AND) ? ST_HASH : ST_DONE;
      ST_HASH: if (round == 4'd10) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // wire store reads
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_a <= store[job.req.src_a[AW-1:0]];
      rd_b <= store[job.req.src_b[AW-1:0]];
      ok_a <= ({20'd0, job.req.src_a} < 32'(WIRE_COUNT));
      ok_b <= ({20'd0, job.req.src_b} < 32'(WIRE_COUNT));
    end
  end

  // final label
  always_comb begin
    unique case (job.req.cmd)
      CMD_START: res_word = '0;
      CMD_LOAD:  res_word = {job.req.word0_hi, job.req.word0_lo};
      CMD_XOR:   res_word = la ^ lb;
      default: begin
        res_word = st_a ^ sa ^ st_b ^ sb;
        if (la[0]) res_word = res_word ^ {job.req.word0_hi, job.req.word0_lo};
        if (lb[0]) res_word = res_word ^ {job.req.word1_hi, job.req.word1_lo} ^ la;
      end
    endcase
  end

  assign wr_en = (state == ST_DONE) && (job.req.cmd != CMD_START)
              && ({20'd0, job.req.dest_wire} < 32'(WIRE_COUNT));

  always_ff @(posedge clk) begin
    if (wr_en) store[job.req.dest_wire[AW-1:0]] <= res_word;
  end

  // aes datapath, one round per cycle for both inputs
  always_ff @(posedge clk) begin
    if (q_pop) job <= q_job;
    if (state == ST_WAIT) begin
      sa    <= hash_in(la, job.tweak_a);
      sb    <= hash_in(lb, job.tweak_b);
      st_a  <= hash_in(la, job.tweak_a) ^ FIXED_KEY;
      st_b  <= hash_in(lb, job.tweak_b) ^ FIXED_KEY;
      rkey  <= next_key(FIXED_KEY, 8'h01);
      rcon  <= 8'h02;
      round <= 4'd1;
    end else if (state == ST_HASH) begin
      st_a  <= aes_round(st_a, rkey, round == 4'd10);
      st_b  <= aes_round(st_b, rkey, round == 4'd10);
      rkey  <= next_key(rkey, rcon);
      rcon  <= xtime(rcon);
      round <= round + 4'd1;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == ST_DONE);
    if (state == ST_DONE) result <= res_word;
  end
endmodule

>>> rtl/half_gates_evaluator.sv
// top level of the half-gates garbled circuit evaluator
//
//  channel   signals                    handshake
//  request   start, busy, req           accepted when start && !busy
//  result    done, result               one-cycle strobe, cannot stall
//  config    cfg_we, cfg_data           written when cfg_we
//
// start, load and xor go through the queue and the read, wait and done states; an
// and gate also runs the ten aes rounds of the two round-iterative cores after the
// registered wire store read. A two-entry queue lets requests be taken while
// the back part works. Reset is synchronous; the wire store is not cleared.
module half_gates_evaluator #(
  parameter int WIRE_COUNT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  hge_pkg::hge_req_t req,
  output logic              done,
  output hge_pkg::hge_res_t result,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data
);
  import hge_pkg::*;

  logic     q_push, q_pop, q_full, q_nonempty;
  hge_job_t q_in, q_out;

  hge_front u_front (
    .clk(clk), .rst(rst), .start(start), .req(req), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .q_full(q_full), .busy(busy), .q_push(q_push), .q_job(q_in)
  );

  hge_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_in), .full(q_full),
    .nonempty(q_nonempty), .pop(q_pop), .dout(q_out)
  );

  hge_back #(.WIRE_COUNT(WIRE_COUNT)) u_back (
    .clk(clk), .rst(rst), .q_nonempty(q_nonempty), .q_job(q_out), .q_pop(q_pop),
    .done(done), .result(result)
  );
endmodule
